[hdl/assert_macros.svh]
// Assertion helpers shared by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: invariant violated");

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication violated");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication violated");

`endif

[hdl/adm_pkg.sv]
package adm_pkg;

    localparam int SAMPLE_BITS_DEF = 10;
    localparam int TIME_BITS       = 32;
    localparam int MAG_BITS        = 11;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 32;

    localparam logic [MAG_BITS-1:0] MAG_MAX = 11'd2047;

    localparam logic [CFG_INDEX_BITS-1:0] REG_POLL_MODE       = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_POLL_PERIOD     = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EVENT_THRESHOLD = 2'd2;

    localparam logic                 POLL_MODE_RESET   = 1'b1;
    localparam logic [TIME_BITS-1:0] POLL_PERIOD_RESET = 32'd100;
    localparam logic [MAG_BITS-1:0]  THRESHOLD_RESET   = 11'd1000;

    typedef struct packed {
        logic busy;
        logic done;
    } sqrt_status_t;

endpackage

[hdl/adm_if.sv]
interface adm_in_if #(
    parameter int SAMPLE_BITS = adm_pkg::SAMPLE_BITS_DEF
);
    import adm_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [TIME_BITS-1:0]          now_ms;
    logic                          data_ready;
    logic signed [SAMPLE_BITS-1:0] accel_x;
    logic signed [SAMPLE_BITS-1:0] accel_y;
    logic signed [SAMPLE_BITS-1:0] accel_z;

    modport source (
        output valid, now_ms, data_ready, accel_x, accel_y, accel_z,
        input  ready
    );
    modport sink (
        input  valid, now_ms, data_ready, accel_x, accel_y, accel_z,
        output ready
    );
endinterface

interface adm_out_if;
    import adm_pkg::*;

    logic                valid;
    logic                ready;
    logic                computed;
    logic [MAG_BITS-1:0] magnitude;
    logic [MAG_BITS-1:0] peak_out;
    logic                event_res;

    modport source (
        output valid, computed, magnitude, peak_out, event_res,
        input  ready
    );
    modport sink (
        input  valid, computed, magnitude, peak_out, event_res,
        output ready
    );
endinterface

interface adm_cfg_if;
    import adm_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

[hdl/adm_lane.sv]
module adm_lane #(
    parameter int SAMPLE_BITS = adm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          load,
    input  logic signed [SAMPLE_BITS-1:0] cur,
    input  logic signed [SAMPLE_BITS-1:0] prev,
    output logic [2*SAMPLE_BITS-1:0]      sq
);
    import adm_pkg::*;

    logic signed [SAMPLE_BITS:0]   diff;
    logic [SAMPLE_BITS:0]          abs_diff;
    logic [SAMPLE_BITS-1:0]        delta_reg;
    logic [SAMPLE_BITS-1:0]        delta_next;
    logic [2*SAMPLE_BITS-1:0]      sq_reg;
    logic [2*SAMPLE_BITS-1:0]      sq_next;

    always_comb
    begin
        diff       = {cur[SAMPLE_BITS-1], cur} - {prev[SAMPLE_BITS-1], prev};
        abs_diff   = diff[SAMPLE_BITS] ? (~diff + 1'b1) : diff;
        delta_next = load ? abs_diff[SAMPLE_BITS-1:0] : delta_reg;
        sq_next    = delta_reg * delta_reg;
    end

    always_ff @(posedge clk)
    begin
        delta_reg <= delta_next;
        sq_reg    <= sq_next;
    end

    assign sq = sq_reg;

endmodule

[hdl/adm_isqrt.sv]
`include "assert_macros.svh"

module adm_isqrt #(
    parameter int ROOT_BITS = adm_pkg::SAMPLE_BITS_DEF + 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [2*ROOT_BITS-1:0]   radicand,
    output adm_pkg::sqrt_status_t    status,
    output logic [ROOT_BITS-1:0]     root
);
    import adm_pkg::*;

    localparam int RAD_BITS   = 2 * ROOT_BITS;
    localparam int REM_BITS   = ROOT_BITS + 2;
    localparam int TRIAL_BITS = REM_BITS + 2;
    localparam int CNT_BITS   = $clog2(ROOT_BITS + 1);

    logic [RAD_BITS-1:0]   rad_reg;
    logic [RAD_BITS-1:0]   rad_next;
    logic [REM_BITS-1:0]   rem_reg;
    logic [REM_BITS-1:0]   rem_next;
    logic [ROOT_BITS-1:0]  root_reg;
    logic [ROOT_BITS-1:0]  root_next;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [CNT_BITS-1:0]   cnt_next;
    logic                  busy_reg;
    logic                  busy_next;
    logic                  done_reg;
    logic                  done_next;
    logic [TRIAL_BITS-1:0] shifted;
    logic [TRIAL_BITS-1:0] subtrahend;
    logic [TRIAL_BITS-1:0] diff;
    logic                  fits;

    always_comb
    begin
        shifted    = {rem_reg, rad_reg[RAD_BITS-1 -: 2]};
        subtrahend = {2'b00, root_reg, 2'b01};
        fits       = shifted >= subtrahend;
        diff       = shifted - subtrahend;

        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_BITS'(ROOT_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next  = {rad_reg[RAD_BITS-3:0], 2'b00};
            rem_next  = fits ? diff[REM_BITS-1:0] : shifted[REM_BITS-1:0];
            root_next = {root_reg[ROOT_BITS-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign root        = root_reg;

    `ASSERT_IMPL(a_start_when_free, clk, rst_n, start, !busy_reg)
    `ASSERT_IMPL(a_done_after_busy, clk, rst_n, done_reg, $past(busy_reg) && !busy_reg)
    `ASSERT_IMPL(a_busy_has_steps, clk, rst_n, busy_reg, cnt_reg != '0)

endmodule

[hdl/accel_delta_magnitude_detector_core.sv]
// Accelerometer delta-magnitude detector.
// The sample channel takes one request per handler call: time, data-ready flag
// and a three-axis sample. The result channel returns exactly one request for
// each sample: the computed flag, latest magnitude, peak and event flag.
// The cfg channel writes poll_mode (index 0), poll_period_ms (index 1) and
// event_threshold (index 2); other indexes are ignored. It is always ready. The
// user must write it only with no sample in flight; the block does not enforce it.
// A sample that takes no reading goes straight to the hold state, and its result
// is registered in the output register once that is free. A reading runs through
// the three axis lanes (delta, square), the sum and the bit-serial square root
// unit, one root bit per cycle, then the hold state and the output register. One
// sample is in flight at a time: the next sample is taken only after the result
// of the last one has been moved into the output register.
// Reset restores the register defaults, clears the stored sample, time, peak
// and latest magnitude, and marks the block unprimed: the first sample after
// reset only stores the sample and time. The finished result waits in an
// output register while the receiver stalls; the next sample is still taken
// and processed, and its result waits until the output register is freed.
`include "assert_macros.svh"

module accel_delta_magnitude_detector_core #(
    parameter int SAMPLE_BITS = adm_pkg::SAMPLE_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    adm_cfg_if.sink   cfg,
    adm_in_if.sink    sample,
    adm_out_if.source result
);
    import adm_pkg::*;

    localparam int SQ_BITS   = 2 * SAMPLE_BITS;
    localparam int ROOT_BITS = SAMPLE_BITS + 1;
    localparam int RAD_BITS  = 2 * ROOT_BITS;
    localparam int CMP_BITS  = (ROOT_BITS > MAG_BITS) ? ROOT_BITS : MAG_BITS;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SQ    = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_ROOT  = 3'd3;
    localparam logic [2:0] ST_HOLD  = 3'd4;

    logic [2:0]                    state_reg;
    logic [2:0]                    state_next;
    logic                          poll_mode_reg;
    logic                          poll_mode_next;
    logic [TIME_BITS-1:0]          poll_period_reg;
    logic [TIME_BITS-1:0]          poll_period_next;
    logic [MAG_BITS-1:0]           threshold_reg;
    logic [MAG_BITS-1:0]           threshold_next;
    logic signed [SAMPLE_BITS-1:0] prev_x_reg;
    logic signed [SAMPLE_BITS-1:0] prev_x_next;
    logic signed [SAMPLE_BITS-1:0] prev_y_reg;
    logic signed [SAMPLE_BITS-1:0] prev_y_next;
    logic signed [SAMPLE_BITS-1:0] prev_z_reg;
    logic signed [SAMPLE_BITS-1:0] prev_z_next;
    logic [TIME_BITS-1:0]          last_read_reg;
    logic [TIME_BITS-1:0]          last_read_next;
    logic [MAG_BITS-1:0]           peak_reg;
    logic [MAG_BITS-1:0]           peak_next;
    logic [MAG_BITS-1:0]           latest_reg;
    logic [MAG_BITS-1:0]           latest_next;
    logic                          primed_reg;
    logic                          primed_next;
    logic                          pend_computed_reg;
    logic                          pend_computed_next;
    logic                          pend_event_reg;
    logic                          pend_event_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          out_computed_reg;
    logic                          out_computed_next;
    logic [MAG_BITS-1:0]           out_mag_reg;
    logic [MAG_BITS-1:0]           out_mag_next;
    logic [MAG_BITS-1:0]           out_peak_reg;
    logic [MAG_BITS-1:0]           out_peak_next;
    logic                          out_event_reg;
    logic                          out_event_next;

    logic                          accept;
    logic                          cfg_write;
    logic [TIME_BITS-1:0]          elapsed;
    logic                          due;
    logic                          lane_load;
    logic                          sqrt_start;
    logic [SQ_BITS-1:0]            sq_x;
    logic [SQ_BITS-1:0]            sq_y;
    logic [SQ_BITS-1:0]            sq_z;
    logic [RAD_BITS-1:0]           sum_sq;
    sqrt_status_t                  sqrt_status;
    logic [ROOT_BITS-1:0]          root;
    logic [CMP_BITS-1:0]           root_ext;
    logic [MAG_BITS-1:0]           mag;

    assign accept    = sample.valid && sample.ready;
    assign cfg_write = cfg.valid && cfg.ready;
    assign lane_load = accept && primed_reg && due;

    adm_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_x (
        .clk  (clk),
        .load (lane_load),
        .cur  (sample.accel_x),
        .prev (prev_x_reg),
        .sq   (sq_x)
    );

    adm_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_y (
        .clk  (clk),
        .load (lane_load),
        .cur  (sample.accel_y),
        .prev (prev_y_reg),
        .sq   (sq_y)
    );

    adm_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_z (
        .clk  (clk),
        .load (lane_load),
        .cur  (sample.accel_z),
        .prev (prev_z_reg),
        .sq   (sq_z)
    );

    assign sum_sq = RAD_BITS'(sq_x) + RAD_BITS'(sq_y) + RAD_BITS'(sq_z);

    adm_isqrt #(.ROOT_BITS(ROOT_BITS)) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sum_sq),
        .status   (sqrt_status),
        .root     (root)
    );

    always_comb
    begin
        elapsed  = sample.now_ms - last_read_reg;
        due      = sample.data_ready || (poll_mode_reg && (elapsed >= poll_period_reg));
        root_ext = CMP_BITS'(root);
        mag      = (root_ext > CMP_BITS'(MAG_MAX)) ? MAG_MAX : root_ext[MAG_BITS-1:0];

        state_next         = state_reg;
        poll_mode_next     = poll_mode_reg;
        poll_period_next   = poll_period_reg;
        threshold_next     = threshold_reg;
        prev_x_next        = prev_x_reg;
        prev_y_next        = prev_y_reg;
        prev_z_next        = prev_z_reg;
        last_read_next     = last_read_reg;
        peak_next          = peak_reg;
        latest_next        = latest_reg;
        primed_next        = primed_reg;
        pend_computed_next = pend_computed_reg;
        pend_event_next    = pend_event_reg;
        out_valid_next     = out_valid_reg;
        out_computed_next  = out_computed_reg;
        out_mag_next       = out_mag_reg;
        out_peak_next      = out_peak_reg;
        out_event_next     = out_event_reg;
        sqrt_start         = 1'b0;

        if (cfg_write)
        begin
            if (cfg.index == REG_POLL_MODE)
            begin
                poll_mode_next = cfg.data[0];
            end
            else if (cfg.index == REG_POLL_PERIOD)
            begin
                poll_period_next = cfg.data;
            end
            else if (cfg.index == REG_EVENT_THRESHOLD)
            begin
                threshold_next = cfg.data[MAG_BITS-1:0];
            end
        end

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pend_computed_next = 1'b0;
                    pend_event_next    = 1'b0;
                    if (!primed_reg || due)
                    begin
                        prev_x_next    = sample.accel_x;
                        prev_y_next    = sample.accel_y;
                        prev_z_next    = sample.accel_z;
                        last_read_next = sample.now_ms;
                    end
                    primed_next = 1'b1;
                    state_next  = lane_load ? ST_SQ : ST_HOLD;
                end
            end
            ST_SQ:
            begin
                state_next = ST_START;
            end
            ST_START:
            begin
                sqrt_start = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (sqrt_status.done)
                begin
                    latest_next        = mag;
                    peak_next          = (mag > peak_reg) ? mag : peak_reg;
                    pend_computed_next = 1'b1;
                    pend_event_next    = mag >= threshold_reg;
                    state_next         = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next    = 1'b1;
                    out_computed_next = pend_computed_reg;
                    out_mag_next      = latest_reg;
                    out_peak_next     = peak_reg;
                    out_event_next    = pend_event_reg;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            poll_mode_reg   <= POLL_MODE_RESET;
            poll_period_reg <= POLL_PERIOD_RESET;
            threshold_reg   <= THRESHOLD_RESET;
            prev_x_reg      <= '0;
            prev_y_reg      <= '0;
            prev_z_reg      <= '0;
            last_read_reg   <= '0;
            peak_reg        <= '0;
            latest_reg      <= '0;
            primed_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            poll_mode_reg   <= poll_mode_next;
            poll_period_reg <= poll_period_next;
            threshold_reg   <= threshold_next;
            prev_x_reg      <= prev_x_next;
            prev_y_reg      <= prev_y_next;
            prev_z_reg      <= prev_z_next;
            last_read_reg   <= last_read_next;
            peak_reg        <= peak_next;
            latest_reg      <= latest_next;
            primed_reg      <= primed_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_computed_reg <= pend_computed_next;
        pend_event_reg    <= pend_event_next;
        out_computed_reg  <= out_computed_next;
        out_mag_reg       <= out_mag_next;
        out_peak_reg      <= out_peak_next;
        out_event_reg     <= out_event_next;
    end

    assign cfg.ready        = 1'b1;
    assign sample.ready     = (state_reg == ST_IDLE);
    assign result.valid     = out_valid_reg;
    assign result.computed  = out_computed_reg;
    assign result.magnitude = out_mag_reg;
    assign result.peak_out  = out_peak_reg;
    assign result.event_res = out_event_reg;

    `ASSERT_NEXT(a_peak_never_falls, clk, rst_n, 1'b1, peak_reg >= $past(peak_reg))
    `ASSERT_ALWAYS(a_latest_within_peak, clk, rst_n, latest_reg <= peak_reg)
    `ASSERT_IMPL(a_event_needs_reading, clk, rst_n, out_valid_reg && out_event_reg,
        out_computed_reg)

endmodule
